@@ hw/rtl/hpte_pkg.sv @@
// Shared types and constants for the histogram plot threshold engine.
package hpte_pkg;

  localparam int NUM_BINS = 256;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_PLOT  = 2'd2;

  // Pixel levels
  localparam logic [7:0] WHITE    = 8'd255;
  localparam logic [7:0] BAR      = 8'd235;
  localparam logic [7:0] BLACK    = 8'd0;
  localparam logic [7:0] LAST_ROW = 8'd255;

  // Configuration
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;
  localparam logic [1:0] ADDR_THRESHOLD  = 2'd0;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

@@ hw/rtl/histogram_plot_threshold_engine.sv @@
// Top level: request control, bin update, plot readout and configuration port.
//
// Histogram plot threshold engine. Each request carries an operation: clear
// empties all 256 bins and the peak count; pixel binarizes gray_pixel against
// the threshold register (255 when strictly above, else 0), counts it in its
// bin (saturating at 2^COUNT_BITS-1) and tracks the peak bin count; plot
// returns one cell of a 256x256 bar chart, 235 inside a bar whose height is
// count*256/peak clamped to 255, with a dashed marker (255/0 on even/odd rows
// 0..254) in the threshold column. A plot request while the peak is zero
// returns 0 with empty_fault set. One request is handled at a time: the
// synchronous bin memory read, then the compare and the read-modify-write
// back into the same memory. A new request is taken while the previous
// result still waits in the output register; a result that is not taken
// stalls the engine in its busy state. Clear takes effect through per-bin
// valid bits, so there is no clearing pass after reset. The threshold
// register sits at byte address 0 of the APB port and should be written
// only while the engine is idle.
module histogram_plot_threshold_engine import hpte_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  gray_pixel,
  input  logic [7:0]  plot_row,
  input  logic [7:0]  plot_column,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_value,
  output logic        empty_fault,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  state;
  logic                  state_next;
  logic [1:0]            op_q;
  logic [7:0]            gray_q;
  logic [7:0]            row_q;
  logic [7:0]            col_q;
  logic [7:0]            threshold;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_inc;
  logic [7:0]            cell_value;
  logic [7:0]            result_value;
  logic                  result_fault;
  logic                  accept;
  logic                  done;
  mem_ctl_t              mem_ctl;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THRESHOLD) ? {24'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_THRESHOLD)) begin
      threshold <= pwdata[7:0];
    end
  end

  // ---------------- request control ----------------
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // result register must be free (or draining) to finish
  assign done     = (state == ST_BUSY) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request payload, held for the compute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      gray_q <= gray_pixel;
      row_q  <= plot_row;
      col_q  <= plot_column;
    end
  end

  // ---------------- bin memory ----------------
  assign mem_ctl.rd_en = accept;
  assign mem_ctl.wr_en = done && (op_q == OP_PIXEL);
  assign mem_ctl.clr   = done && (op_q == OP_CLEAR);

  // saturating increment
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

  hpte_bin_mem #(
    .COUNT_BITS(COUNT_BITS)
  ) u_bin_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .rd_addr  ((operation == OP_PLOT) ? plot_column : gray_pixel),
    .wr_addr  (gray_q),
    .wr_data  (count_inc),
    .rd_count (count)
  );

  always_ff @(posedge clk) begin
    if (rst || mem_ctl.clr) begin
      peak <= '0;
    end else if (mem_ctl.wr_en && (count_inc > peak)) begin
      peak <= count_inc;
    end
  end

  // ---------------- plot readout ----------------
  hpte_plot_cell #(
    .COUNT_BITS(COUNT_BITS)
  ) u_plot_cell (
    .row       (row_q),
    .column    (col_q),
    .threshold (threshold),
    .count     (count),
    .peak      (peak),
    .value     (cell_value)
  );

  always_comb begin
    result_value = BLACK;
    result_fault = 1'b0;
    case (op_q)
      OP_PIXEL: begin
        result_value = (gray_q > threshold) ? WHITE : BLACK;
      end
      OP_PLOT: begin
        if (peak == '0) begin
          result_fault = 1'b1;
        end else begin
          result_value = cell_value;
        end
      end
      default: begin
        result_value = BLACK;
      end
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pixel_value <= result_value;
      empty_fault <= result_fault;
    end
  end

  // ---------------- assertions ----------------
  // peak never falls behind a count just written back
  assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |=> (peak >= $past(count_inc)))
    else $error("peak count below updated bin count");

  // a finished clear leaves an empty histogram
  assert property (@(posedge clk) disable iff (rst)
    mem_ctl.clr |=> (peak == '0))
    else $error("peak count not cleared");

  // fault results carry no pixel
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_fault) |-> (pixel_value == BLACK))
    else $error("empty fault with nonzero pixel");

  // a request is taken only when the previous one has finished
  assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == ST_BUSY) && !$past(state == ST_BUSY)))
    else $error("request accepted while busy");

endmodule

@@ hw/rtl/hpte_bin_mem.sv @@
// Histogram bin memory with per-entry valid bits, so a clear needs no pass over the entries.
module hpte_bin_mem import hpte_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mem_ctl_t              ctl,
  input  logic [7:0]            rd_addr,
  input  logic [7:0]            wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] rd_count
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_count = rd_valid ? rd_data : '0;

endmodule

@@ hw/rtl/hpte_plot_cell.sv @@
// Bar chart cell evaluation: bar height compare and threshold marker.
module hpte_plot_cell import hpte_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic [7:0]            row,
  input  logic [7:0]            column,
  input  logic [7:0]            threshold,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [COUNT_BITS-1:0] peak,
  output logic [7:0]            value
);

  localparam int PROD_BITS = COUNT_BITS + 9;

  logic [8:0]           row_inc;
  logic [PROD_BITS-1:0] lhs;
  logic [PROD_BITS-1:0] rhs;
  logic                 in_bar;
  logic                 marker;

  // row < floor(count*256/peak)  <=>  (row+1)*peak <= count*256
  // clamp to 255 folds into excluding the top row
  assign row_inc = {1'b0, row} + 9'd1;
  assign lhs     = PROD_BITS'(row_inc) * PROD_BITS'(peak);
  assign rhs     = {1'b0, count, 8'd0};
  assign in_bar  = (row != LAST_ROW) && (lhs <= rhs);
  assign marker  = (column == threshold) && (row != LAST_ROW);

  always_comb begin
    if (marker) begin
      value = row[0] ? BLACK : WHITE;
    end else if (in_bar) begin
      value = BAR;
    end else begin
      value = BLACK;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the histogram plot threshold engine.
module testbench;
  import hpte_pkg::*;

  // Narrow bins so that saturation is reachable in a few hundred requests.
  localparam int CNT_BITS = 8;
  localparam logic [CNT_BITS-1:0] TALLY_MAX = {CNT_BITS{1'b1}};
  localparam logic [1:0] OP_NONE = 2'd3;   // unused operation code
  localparam int PLOT_SCALE = 256;         // bar height = count * 256 / peak
  localparam int HEIGHT_CLAMP = 255;
  localparam int MAX_GAP = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASE_LEN = 90;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       fault;
  } plot_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_CLEAR;
  logic [7:0]  gray_pixel = '0;
  logic [7:0]  plot_row = '0;
  logic [7:0]  plot_column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_value;
  logic        empty_fault;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_THRESHOLD;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the engine state, updated in request order.
  logic [CNT_BITS-1:0] tally [NUM_BINS];
  logic [CNT_BITS-1:0] tally_peak;
  logic [7:0]          cut_level;
  plot_result_t        pending_results[$];

  bit no_idle = 1'b0;       // both sides run without gaps while set
  int errors = 0;
  int cycles = 0;
  int n_pixels = 0, n_plots = 0, n_clears = 0, n_unused = 0, n_faults = 0;
  int n_settings = 0;

  histogram_plot_threshold_engine #(.COUNT_BITS(CNT_BITS)) dut (.*);

  always #1 clk = ~clk;

  // Height of the bar in a column, clamped to the plot.
  function automatic int unsigned bar_height(input logic [7:0] col);
    longint unsigned h;
    if (tally_peak == '0) return 0;
    h = tally[col];
    h = (h * PLOT_SCALE) / tally_peak;
    return (h > HEIGHT_CLAMP) ? HEIGHT_CLAMP : int'(h);
  endfunction

  // Applies one request to the shadow state and returns what the engine must give.
  function automatic plot_result_t engine_result(input logic [1:0] op,
                                                 input logic [7:0] gray,
                                                 input logic [7:0] row,
                                                 input logic [7:0] col);
    plot_result_t r;
    r = '0;
    case (op)
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        tally_peak = '0;
      end
      OP_PIXEL: begin
        r.value = (gray > cut_level) ? WHITE : BLACK;
        if (tally[gray] != TALLY_MAX) tally[gray] = tally[gray] + 1'b1;
        if (tally[gray] > tally_peak) tally_peak = tally[gray];
      end
      OP_PLOT: begin
        if (tally_peak == '0)
          r.fault = 1'b1;
        else if (col == cut_level && row != LAST_ROW)
          r.value = row[0] ? BLACK : WHITE;   // dashed marker
        else
          r.value = (int'(row) < bar_height(col)) ? BAR : BLACK;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Monitor: predicts on every accepted request, checks every accepted result.
  always @(posedge clk) begin
    plot_result_t want;
    if (rst) begin
      foreach (tally[i]) tally[i] = '0;
      tally_peak = '0;
      cut_level = THRESHOLD_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD)
        cut_level = pwdata[7:0];
      if (in_valid && in_ready) begin
        case (operation)
          OP_CLEAR: n_clears++;
          OP_PIXEL: n_pixels++;
          OP_PLOT:  n_plots++;
          default:  n_unused++;
        endcase
        pending_results.push_back(engine_result(operation, gray_pixel, plot_row, plot_column));
      end
      if (out_valid && out_ready) begin
        if (empty_fault) n_faults++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: result with no request pending: pixel_value %0d empty_fault %0b",
                     $time, pixel_value, empty_fault);
        end else begin
          want = pending_results.pop_front();
          if (pixel_value !== want.value) begin
            errors++;
            if (errors <= PRINT_CAP)
              $display("%0t: pixel_value expected %0d got %0d", $time, want.value, pixel_value);
          end
          if (empty_fault !== want.fault) begin
            errors++;
            if (errors <= PRINT_CAP)
              $display("%0t: empty_fault expected %0b got %0b", $time, want.fault, empty_fault);
          end
        end
      end
    end
  end

  // Result side: random stalls after a result, sometimes also while nothing is offered.
  always @(posedge clk) begin
    int stall_left;
    int w;
    if (rst) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left--;
    end else if (!no_idle && (out_valid || $urandom_range(0, 7) == 0)) begin
      w = $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        out_ready <= 1'b0;
        stall_left = w - 1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one request; returns at the edge where it is accepted, valid still high.
  task automatic send_request(input logic [1:0] op, input logic [7:0] gray,
                              input logic [7:0] row, input logic [7:0] col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    gray_pixel  <= gray;
    plot_row    <= row;
    plot_column <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Drops valid and waits until every result is in.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [7:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_THRESHOLD;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, want}) begin
      errors++;
      $display("%0t: threshold read expected %0d got %0d", $time, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Threshold change: only with the engine idle, then read back.
  task automatic set_threshold(input logic [7:0] level);
    quiesce();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_THRESHOLD;
    pwdata  <= {24'b0, level};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
    apb_read_check(level);
  endtask

  // Reset value of the threshold, empty plot reads, unused code, clear on empty.
  task automatic test_reset_state();
    apb_read_check(THRESHOLD_RESET);
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd0);
    send_request(OP_NONE, any_byte(), any_byte(), any_byte());
    send_request(OP_CLEAR, any_byte(), any_byte(), any_byte());
    send_request(OP_PLOT, any_byte(), LAST_ROW, THRESHOLD_RESET);
  endtask

  // Strictly-greater compare at the default and at both extreme thresholds.
  task automatic test_binarize_edges();
    send_request(OP_PIXEL, 8'd128, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd129, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd0, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd255, any_byte(), any_byte());
    set_threshold(8'd0);
    send_request(OP_PIXEL, 8'd0, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd1, any_byte(), any_byte());
    set_threshold(8'd255);
    send_request(OP_PIXEL, 8'd255, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd254, any_byte(), any_byte());
  endtask

  // Marker rows, last row of the marker column, bar top and clamp, clear then fault.
  task automatic test_plot_reads();
    set_threshold(THRESHOLD_RESET);
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd128);
    send_request(OP_PLOT, any_byte(), 8'd1, 8'd128);
    send_request(OP_PLOT, any_byte(), 8'd254, 8'd128);
    send_request(OP_PLOT, any_byte(), LAST_ROW, 8'd128);
    send_request(OP_PLOT, any_byte(), 8'd254, 8'd0);
    send_request(OP_PLOT, any_byte(), LAST_ROW, 8'd0);
    send_request(OP_PLOT, any_byte(), 8'd127, 8'd129);
    send_request(OP_PLOT, any_byte(), 8'd128, 8'd129);
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd255);
    send_request(OP_NONE, any_byte(), any_byte(), any_byte());
    send_request(OP_CLEAR, any_byte(), any_byte(), any_byte());
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd0);
  endtask

  // One bin driven past its top count; the peak must stop there too.
  task automatic test_saturation();
    set_threshold(8'd255);
    send_request(OP_CLEAR, any_byte(), any_byte(), any_byte());
    repeat (int'(TALLY_MAX) + 4) send_request(OP_PIXEL, 8'd7, any_byte(), any_byte());
    send_request(OP_PIXEL, 8'd255, any_byte(), any_byte());
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd7);
    send_request(OP_PLOT, any_byte(), 8'd254, 8'd7);
    send_request(OP_PLOT, any_byte(), LAST_ROW, 8'd7);
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd255);
    send_request(OP_PLOT, any_byte(), 8'd1, 8'd255);
    send_request(OP_PLOT, any_byte(), LAST_ROW, 8'd255);
    send_request(OP_PLOT, any_byte(), 8'd0, 8'd8);
    send_request(OP_PIXEL, 8'd7, any_byte(), any_byte());
  endtask

  // Random phases, one per threshold setting. Pixels crowd into a few hot bins
  // so bars get tall, and plot rows often land right at a bar top.
  task automatic test_random();
    logic [7:0] levels [4];
    logic [7:0] hot [4];
    logic [7:0] col;
    logic [7:0] gray;
    int roll;
    int row;
    levels[0] = any_byte();
    levels[1] = 8'd0;
    levels[2] = 8'd255;
    levels[3] = any_byte();
    foreach (levels[p]) begin
      no_idle = 1'b0;
      set_threshold(levels[p]);
      foreach (hot[k]) hot[k] = any_byte();
      for (int i = 0; i < RANDOM_PHASE_LEN; i++) begin
        no_idle = (i % 60) < 15;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          gray = ($urandom_range(0, 1) == 0) ? hot[$urandom_range(0, 3)] : any_byte();
          send_request(OP_PIXEL, gray, any_byte(), any_byte());
        end else if (roll < 88) begin
          roll = $urandom_range(0, 99);
          col = (roll < 20) ? cut_level : (roll < 60) ? hot[$urandom_range(0, 3)] : any_byte();
          if ($urandom_range(0, 1) == 0) begin
            row = int'(bar_height(col)) + int'($urandom_range(0, 2)) - 1;
            if (row < 0) row = 0;
            if (row > 255) row = 255;
          end else begin
            row = $urandom_range(0, 255);
          end
          send_request(OP_PLOT, any_byte(), 8'(row), col);
        end else if (roll < 94) begin
          send_request(OP_CLEAR, any_byte(), any_byte(), any_byte());
        end else begin
          send_request(OP_NONE, any_byte(), any_byte(), any_byte());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_binarize_edges();
    test_plot_reads();
    test_saturation();
    test_random();
    quiesce();
    $display("Checked %0d pixel, %0d plot (%0d empty-plot faults), %0d clear, %0d unused-code",
             n_pixels, n_plots, n_faults, n_clears, n_unused);
    $display("requests across %0d threshold writes incl. 0 and 255; %0d mismatches",
             n_settings, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hpte_pkg.sv
hw/rtl/hpte_bin_mem.sv
hw/rtl/hpte_plot_cell.sv
hw/rtl/histogram_plot_threshold_engine.sv
dv/testbench.sv
